// File: rtl/earliest_nail_prefix_cover_search_assert.svh
// Assertion macros for the earliest nail prefix cover search block.
// Expects clk and rst_n in the scope of the module that includes this file.
`ifndef EARLIEST_NAIL_PREFIX_COVER_SEARCH_ASSERT_SVH
`define EARLIEST_NAIL_PREFIX_COVER_SEARCH_ASSERT_SVH

// Same-cycle implication under the synchronous reset.
`define ENP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication under the synchronous reset.
`define ENP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

// File: rtl/enp_pkg.sv
// Shared types and constants for the earliest nail prefix cover search block.
// No dependencies.
`default_nettype none

package enp_pkg;

  localparam int POS_W    = 12;  // width of the position fields
  localparam int NEEDED_W = 11;  // width of the nails_needed result
  localparam int FUNC_W   = 2;

  localparam int DEF_MAX_PLANKS   = 1024;
  localparam int DEF_MAX_NAILS    = 1024;
  localparam int DEF_MAX_POSITION = 2048;

  typedef enum logic [FUNC_W-1:0] {
    FN_CLEAR = 2'd0,
    FN_PLANK = 2'd1,
    FN_NAIL  = 2'd2,
    FN_SOLVE = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_INIT,    // wipe the mark memory after reset
    ST_IDLE,    // take loads and solve requests
    ST_SEARCH,  // test the search range, pick the trial count
    ST_MARK,    // mark positions of the first trial nails
    ST_PREFIX,  // sweep positions, build prefix counts, wipe marks
    ST_CHECK,   // test every plank range against the prefix counts
    ST_DECIDE,  // narrow the search range
    ST_DONE     // present the result word
  } state_t;

endpackage

`default_nettype wire

// File: rtl/earliest_nail_prefix_cover_search.sv
// Earliest nail prefix cover search: plank and nail stores, binary search over
// nail prefixes with a per-trial position sweep. Depends on enp_pkg and
// earliest_nail_prefix_cover_search_assert.svh.
//
//  channel | ports                         | direction | contents
//  --------+-------------------------------+-----------+------------------------------
//  in_     | in_tvalid/tready/tdata/tuser  | input     | func, plank range, nail position
//  out_    | out_tvalid/tready/tdata/tuser | output    | nails_needed, found
//
// Clear, plank and nail words do not leave ST_IDLE, so the block stays ready after each one.
// A solve word runs a binary search of about log2(nail_count+1) trials; each trial sweeps the
// nail store up to the trial count, every position of the mark/prefix memories and the
// plank stores.
// After reset a clearing pass wipes every position of the mark memory; in_tready
// stays low until it ends. A stalled result word holds in the output register; loads are
// still taken, and a further solve is searched but its result waits until the pending word is taken.
`default_nettype none

module earliest_nail_prefix_cover_search
  import enp_pkg::*;
#(
  parameter int MAX_PLANKS   = DEF_MAX_PLANKS,
  parameter int MAX_NAILS    = DEF_MAX_NAILS,
  parameter int MAX_POSITION = DEF_MAX_POSITION
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [39:0] in_tdata,   // [11:0] plank_start, [23:12] plank_end,
                                       // [35:24] nail_position, [39:36] zero
  input  wire logic [1:0]  in_tuser,   // [1:0] func
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // [10:0] nails_needed, [15:11] zero
  output logic             out_tuser   // [0] found
);

  localparam int PLW = $clog2(MAX_PLANKS + 1);                      // plank count
  localparam int NCW = $clog2(MAX_NAILS + 1);                       // nail count
  localparam int PAW = (MAX_PLANKS > 1) ? $clog2(MAX_PLANKS) : 1;   // plank address
  localparam int NAW = (MAX_NAILS > 1) ? $clog2(MAX_NAILS) : 1;     // nail address
  localparam int PD  = MAX_POSITION + 1;                            // position depth
  localparam int PW  = $clog2(PD);                                  // position index
  localparam int PCW = (PW > POS_W) ? PW : POS_W;                   // position compare
  localparam int SW  = NCW + 1;                                     // search bounds
  localparam int MW  = (PLW > NCW) ? PLW : NCW;
  localparam int IW  = ((MW > PW) ? MW : PW) + 1;                   // sweep counter
  localparam int BW  = (NCW > NEEDED_W) ? NCW : NEEDED_W;

  // Stores and per-trial memories
  logic [POS_W-1:0] start_mem  [MAX_PLANKS];
  logic [POS_W-1:0] end_mem    [MAX_PLANKS];
  logic [POS_W-1:0] nail_mem   [MAX_NAILS];
  logic             mark_mem   [PD];
  logic [NCW-1:0]   prefix_mem [PD];

  state_t           state_r, state_nxt;
  logic [PLW-1:0]   plank_cnt_r;
  logic [NCW-1:0]   nail_cnt_r;
  logic [SW-1:0]    low_r, low_nxt, high_r, high_nxt, mid_r, mid_nxt;
  logic [NCW-1:0]   best_r, best_nxt;
  logic             hit_r, hit_nxt, fail_r, fail_nxt;
  logic [IW-1:0]    idx_r, idx_nxt;
  logic             v1_r, v1_nxt, v2_r, v2_nxt;
  logic [NCW-1:0]   acc_r, acc_nxt;
  logic [PW-1:0]    a1_r, a1_nxt;
  logic             bad2_r, bad2_nxt;
  logic             out_tvalid_r, out_tvalid_nxt;
  logic [NEEDED_W-1:0] out_needed_r, out_needed_nxt;
  logic             out_found_r, out_found_nxt;

  // Memory read data
  logic [POS_W-1:0] start_rd_r, end_rd_r, nail_rd_r;
  logic             mark_rd_r;
  logic [NCW-1:0]   pre_hi_r, pre_lo_r;

  // Memory controls
  logic             mark_we, mark_wdata;
  logic [PW-1:0]    mark_waddr;
  logic             prefix_we;
  logic [PW-1:0]    prefix_waddr, pre_hi_addr, pre_lo_addr;
  logic [NCW-1:0]   prefix_wdata;

  // Work values
  logic             in_acc;
  func_t            in_func;
  logic [SW:0]      mid_sum;
  logic [PCW-1:0]   nail_ext, lo_c, hi_c, lo_m1, end_ext;
  logic [NCW-1:0]   acc_sum;
  logic [BW-1:0]    best_ext;

  assign in_func   = func_t'(in_tuser);
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = {{(16 - NEEDED_W){1'b0}}, out_needed_r};
  assign out_tuser  = out_found_r;

  assign mid_sum  = {1'b0, low_r} + {1'b0, high_r};
  assign nail_ext = PCW'(nail_rd_r);
  assign end_ext  = PCW'(end_rd_r);
  assign lo_c     = (start_rd_r == '0) ? PCW'(1) : PCW'(start_rd_r);
  assign hi_c     = (end_ext > PCW'(MAX_POSITION)) ? PCW'(MAX_POSITION) : end_ext;
  assign lo_m1    = lo_c - PCW'(1);
  assign acc_sum  = acc_r + NCW'(mark_rd_r);
  assign best_ext = BW'(best_r);

  assign pre_hi_addr = hi_c[PW-1:0];
  assign pre_lo_addr = lo_m1[PW-1:0];

  // Next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_INIT:   if (idx_r == IW'(MAX_POSITION)) state_nxt = ST_IDLE;
      ST_IDLE:   if (in_acc && in_func == FN_SOLVE) state_nxt = ST_SEARCH;
      ST_SEARCH: state_nxt = (low_r <= high_r) ? ST_MARK : ST_DONE;
      ST_MARK:   if (idx_r == IW'(mid_r) && !v1_r) state_nxt = ST_PREFIX;
      ST_PREFIX: if (idx_r > IW'(MAX_POSITION) && !v1_r) state_nxt = ST_CHECK;
      ST_CHECK:  if (idx_r == IW'(plank_cnt_r) && !v1_r && !v2_r) state_nxt = ST_DECIDE;
      ST_DECIDE: state_nxt = ST_SEARCH;
      ST_DONE:   if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    idx_nxt        = idx_r;
    v1_nxt         = 1'b0;
    v2_nxt         = 1'b0;
    low_nxt        = low_r;
    high_nxt       = high_r;
    mid_nxt        = mid_r;
    best_nxt       = best_r;
    hit_nxt        = hit_r;
    fail_nxt       = fail_r;
    acc_nxt        = acc_r;
    a1_nxt         = a1_r;
    bad2_nxt       = bad2_r;
    mark_we        = 1'b0;
    mark_waddr     = a1_r;
    mark_wdata     = 1'b0;
    prefix_we      = 1'b0;
    prefix_waddr   = a1_r;
    prefix_wdata   = acc_sum;
    out_tvalid_nxt = out_tvalid_r && !out_tready;
    out_needed_nxt = out_needed_r;
    out_found_nxt  = out_found_r;

    case (state_r)
      ST_INIT: begin
        mark_we    = 1'b1;
        mark_waddr = idx_r[PW-1:0];
        idx_nxt    = idx_r + IW'(1);
      end
      ST_IDLE: begin
        if (in_acc && in_func == FN_SOLVE) begin
          low_nxt  = SW'(1);
          high_nxt = SW'(nail_cnt_r);
          best_nxt = '0;
          hit_nxt  = 1'b0;
        end
      end
      ST_SEARCH: begin
        mid_nxt  = mid_sum[SW:1];
        fail_nxt = 1'b0;
        acc_nxt  = '0;
      end
      ST_MARK: begin
        // Issue nail reads, then set the mark of each in-range position
        if (idx_r < IW'(mid_r)) begin
          idx_nxt = idx_r + IW'(1);
          v1_nxt  = 1'b1;
        end
        if (v1_r && nail_ext != '0 && nail_ext <= PCW'(MAX_POSITION)) begin
          mark_we    = 1'b1;
          mark_waddr = nail_ext[PW-1:0];
          mark_wdata = 1'b1;
        end
      end
      ST_PREFIX: begin
        // Running count of marks; wipe each mark once it is counted
        if (idx_r <= IW'(MAX_POSITION)) begin
          idx_nxt = idx_r + IW'(1);
          v1_nxt  = 1'b1;
          a1_nxt  = idx_r[PW-1:0];
        end
        if (v1_r) begin
          acc_nxt   = acc_sum;
          prefix_we = 1'b1;
          mark_we   = 1'b1;
        end
      end
      ST_CHECK: begin
        if (idx_r < IW'(plank_cnt_r)) begin
          idx_nxt = idx_r + IW'(1);
          v1_nxt  = 1'b1;
        end
        if (v1_r) begin
          v2_nxt   = 1'b1;
          bad2_nxt = (lo_c > hi_c);
        end
        if (v2_r && (bad2_r || pre_hi_r == pre_lo_r)) begin
          fail_nxt = 1'b1;
        end
      end
      ST_DECIDE: begin
        if (!fail_r) begin
          best_nxt = mid_r[NCW-1:0];
          hit_nxt  = 1'b1;
          high_nxt = mid_r - SW'(1);
        end else begin
          low_nxt = mid_r + SW'(1);
        end
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_needed_nxt = best_ext[NEEDED_W-1:0];
          out_found_nxt  = hit_r;
        end
      end
      default: begin
        idx_nxt = '0;
      end
    endcase

    // Restart the sweep counter on every phase change
    if (state_nxt != state_r) begin
      idx_nxt = '0;
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_INIT;
      plank_cnt_r  <= '0;
      nail_cnt_r   <= '0;
      low_r        <= SW'(1);
      high_r       <= '0;
      idx_r        <= '0;
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      low_r        <= low_nxt;
      high_r       <= high_nxt;
      idx_r        <= idx_nxt;
      v1_r         <= v1_nxt;
      v2_r         <= v2_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (in_acc) begin
        case (in_func)
          FN_CLEAR: begin
            plank_cnt_r <= '0;
            nail_cnt_r  <= '0;
          end
          FN_PLANK: if (plank_cnt_r < PLW'(MAX_PLANKS)) plank_cnt_r <= plank_cnt_r + PLW'(1);
          FN_NAIL:  if (nail_cnt_r < NCW'(MAX_NAILS)) nail_cnt_r <= nail_cnt_r + NCW'(1);
          default:  ;
        endcase
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    mid_r        <= mid_nxt;
    best_r       <= best_nxt;
    hit_r        <= hit_nxt;
    fail_r       <= fail_nxt;
    acc_r        <= acc_nxt;
    a1_r         <= a1_nxt;
    bad2_r       <= bad2_nxt;
    out_needed_r <= out_needed_nxt;
    out_found_r  <= out_found_nxt;
  end

  // Plank and nail stores: write on load, read at the sweep index
  always_ff @(posedge clk) begin
    if (in_acc && in_func == FN_PLANK && plank_cnt_r < PLW'(MAX_PLANKS)) begin
      start_mem[plank_cnt_r[PAW-1:0]] <= in_tdata[11:0];
      end_mem[plank_cnt_r[PAW-1:0]]   <= in_tdata[23:12];
    end
    if (in_acc && in_func == FN_NAIL && nail_cnt_r < NCW'(MAX_NAILS)) begin
      nail_mem[nail_cnt_r[NAW-1:0]] <= in_tdata[35:24];
    end
    start_rd_r <= start_mem[idx_r[PAW-1:0]];
    end_rd_r   <= end_mem[idx_r[PAW-1:0]];
    nail_rd_r  <= nail_mem[idx_r[NAW-1:0]];
  end

  // Position mark memory
  always_ff @(posedge clk) begin
    if (mark_we) begin
      mark_mem[mark_waddr] <= mark_wdata;
    end
    mark_rd_r <= mark_mem[idx_r[PW-1:0]];
  end

  // Prefix count memory: one write port, two read ports for a plank range
  always_ff @(posedge clk) begin
    if (prefix_we) begin
      prefix_mem[prefix_waddr] <= prefix_wdata;
    end
    pre_hi_r <= prefix_mem[pre_hi_addr];
    pre_lo_r <= prefix_mem[pre_lo_addr];
  end

`include "earliest_nail_prefix_cover_search_assert.svh"

  `ENP_ASSERT_NOW(a_range_check_in_check, v2_r, state_r == ST_CHECK, "range check outside check phase")
  `ENP_ASSERT_NOW(a_high_bounded, state_r == ST_SEARCH, high_r <= SW'(nail_cnt_r), "search bound above nail count")
  `ENP_ASSERT_NOW(a_mid_in_range, state_r == ST_MARK, mid_r != '0 && mid_r <= SW'(nail_cnt_r), "trial count out of range")
  `ENP_ASSERT_NOW(a_miss_is_zero, out_tvalid_r && !out_found_r, out_needed_r == '0, "nonzero count without a cover")

endmodule

`default_nettype wire
